@@ rtl/fets_pkg.sv @@
// package for fraction_extreme_tie_select
// register map, config struct and shared constants; no dependencies
`default_nettype none

package fets_pkg;

  localparam int unsigned ValueBitsDefault = 16;
  localparam int unsigned DenBitsW         = 5;
  localparam int unsigned CfgAddrW         = 3;
  localparam int unsigned CfgDataW         = 32;

  localparam logic [CfgAddrW-1:0] AddrSelectMode    = 3'd0;
  localparam logic [CfgAddrW-1:0] AddrDenCompareBits = 3'd4;

  typedef struct packed {
    logic                select_mode;
    logic [DenBitsW-1:0] den_compare_bits;
  } fets_cfg_t;

endpackage

`default_nettype wire

@@ rtl/fets_cmp.sv @@
// cross-product compare of held and offered fraction with denominator tie-break
// depends on fets_pkg
`default_nettype none

module fets_cmp #(
  parameter int unsigned VALUE_BITS = fets_pkg::ValueBitsDefault
) (
  input  fets_pkg::fets_cfg_t   cfg_i,
  input  logic [VALUE_BITS-1:0] held_num_i,
  input  logic [VALUE_BITS-1:0] held_den_i,
  input  logic [VALUE_BITS-1:0] offer_num_i,
  input  logic [VALUE_BITS-1:0] offer_den_i,
  output logic                  keep_held_o
);
  import fets_pkg::*;

  localparam int unsigned ProdW = 2 * VALUE_BITS;

  logic [ProdW-1:0]      held_x;
  logic [ProdW-1:0]      offer_x;
  logic [VALUE_BITS-1:0] den_mask;
  logic [VALUE_BITS-1:0] held_den_m;
  logic [VALUE_BITS-1:0] offer_den_m;
  logic                  full_width;
  logic                  prod_pref;
  logic                  prod_eq;
  logic                  den_pref;

  assign held_x  = ProdW'(held_num_i) * ProdW'(offer_den_i);
  assign offer_x = ProdW'(offer_num_i) * ProdW'(held_den_i);

  assign full_width = (cfg_i.den_compare_bits == '0) ||
                      ({1'b0, cfg_i.den_compare_bits} >= 6'(VALUE_BITS));

  for (genvar i = 0; i < VALUE_BITS; i++) begin : g_mask
    assign den_mask[i] = full_width || (6'(i) < {1'b0, cfg_i.den_compare_bits});
  end

  assign held_den_m  = held_den_i & den_mask;
  assign offer_den_m = offer_den_i & den_mask;

  always_comb begin
    if (cfg_i.select_mode) begin
      prod_pref = held_x < offer_x;
      den_pref  = held_den_m < offer_den_m;
    end else begin
      prod_pref = held_x > offer_x;
      den_pref  = held_den_m > offer_den_m;
    end
  end

  assign prod_eq     = held_x == offer_x;
  assign keep_held_o = prod_pref || (prod_eq && den_pref);

endmodule

`default_nettype wire

@@ rtl/fraction_extreme_tie_select.sv @@
// top level of fraction_extreme_tie_select
// depends on fets_pkg and fets_cmp
//
// usage: fractions stream in on the s_axis channel (numerator low, denominator
// high in tdata, tlast marks the final fraction of a set). the block keeps the
// greatest (select_mode 0) or least (select_mode 1) fraction by exact cross
// products; on equal products the low den_compare_bits denominator bits break
// the tie the same way, else the newer fraction wins. on the tlast word the
// chosen fraction leaves on m_axis (numerator low, denominator high) and the
// held state clears.
// an accepted word is registered in the input register and compared there
// against the held fraction; a tlast word's result is then registered in the
// result register that drives m_axis. throughput is one word per cycle while
// no tlast word waits, set by the single compare stage feeding the held register.
// reset clears all valid flags and the registers to mode 0, full-width tie-break.
// when m_axis stalls with a result waiting, non-last words still flow; a tlast
// word waits in the input register until the result register frees up.
// configuration is to be written over the apb port while the stream is idle; the block does not enforce it.
`default_nettype none

module fraction_extreme_tie_select #(
  parameter int unsigned VALUE_BITS = fets_pkg::ValueBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // apb
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fets_pkg::CfgAddrW-1:0]     paddr,
  input  logic [fets_pkg::CfgDataW-1:0]     pwdata,
  output logic [fets_pkg::CfgDataW-1:0]     prdata,
  output logic                              pready,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [2*VALUE_BITS-1:0]           s_axis_tdata,  // numerator, denominator
  input  logic                              s_axis_tlast,  // last_item
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [2*VALUE_BITS-1:0]           m_axis_tdata   // best_numerator, best_denominator
);
  import fets_pkg::*;

  fets_cfg_t cfg_q, cfg_d;

  logic                  in_valid_q, in_valid_d;
  logic                  in_last_q;
  logic [VALUE_BITS-1:0] in_num_q;
  logic [VALUE_BITS-1:0] in_den_q;

  logic                  hold_valid_q, hold_valid_d;
  logic [VALUE_BITS-1:0] held_num_q, held_num_d;
  logic [VALUE_BITS-1:0] held_den_q, held_den_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_num_q, out_num_d;
  logic [VALUE_BITS-1:0] out_den_q, out_den_d;

  logic                  cfg_wr;
  logic                  out_free;
  logic                  proc_fire;
  logic                  in_fire;
  logic                  keep_held;
  logic                  take_new;
  logic [VALUE_BITS-1:0] sel_num;
  logic [VALUE_BITS-1:0] sel_den;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      if (paddr == AddrSelectMode) begin
        cfg_d.select_mode = pwdata[0];
      end
      if (paddr == AddrDenCompareBits) begin
        cfg_d.den_compare_bits = pwdata[DenBitsW-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrSelectMode) begin
      prdata = CfgDataW'(cfg_q.select_mode);
    end else if (paddr == AddrDenCompareBits) begin
      prdata = CfgDataW'(cfg_q.den_compare_bits);
    end
  end

  // handshake
  assign out_free      = !out_valid_q || m_axis_tready;
  assign proc_fire     = in_valid_q && (!in_last_q || out_free);
  assign s_axis_tready = !in_valid_q || proc_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = in_fire || (in_valid_q && !proc_fire);

  fets_cmp #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .cfg_i       (cfg_q),
    .held_num_i  (held_num_q),
    .held_den_i  (held_den_q),
    .offer_num_i (in_num_q),
    .offer_den_i (in_den_q),
    .keep_held_o (keep_held)
  );

  assign take_new = !hold_valid_q || !keep_held;
  assign sel_num  = take_new ? in_num_q : held_num_q;
  assign sel_den  = take_new ? in_den_q : held_den_q;

  always_comb begin
    hold_valid_d = hold_valid_q;
    held_num_d   = held_num_q;
    held_den_d   = held_den_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_num_d    = out_num_q;
    out_den_d    = out_den_q;
    if (proc_fire) begin
      if (in_last_q) begin
        hold_valid_d = 1'b0;
        held_num_d   = '0;
        held_den_d   = '0;
        out_valid_d  = 1'b1;
        out_num_d    = sel_num;
        out_den_d    = sel_den;
      end else begin
        hold_valid_d = 1'b1;
        held_num_d   = sel_num;
        held_den_d   = sel_den;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q        <= '0;
      in_valid_q   <= 1'b0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      in_valid_q   <= in_valid_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_num_q  <= s_axis_tdata[VALUE_BITS-1:0];
      in_den_q  <= s_axis_tdata[2*VALUE_BITS-1:VALUE_BITS];
      in_last_q <= s_axis_tlast;
    end
    held_num_q <= held_num_d;
    held_den_q <= held_den_d;
    out_num_q  <= out_num_d;
    out_den_q  <= out_den_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_den_q, out_num_q};

  // checks
  a_last_clears_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && in_last_q) |=> (!hold_valid_q && out_valid_q))
    else $error("held fraction not cleared after last word");

  a_nonlast_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && !in_last_q) |=> hold_valid_q)
    else $error("held flag not set after a non-last word");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(proc_fire && in_last_q))
    else $error("result without a processed last word");

  a_stall_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && in_last_q && out_valid_q))
    else $error("input stalled without a blocked last word");

endmodule

`default_nettype wire

@@ test/tb_fraction_extreme_tie_select.sv @@
// testbench for fraction_extreme_tie_select: drives fraction sets over the input stream,
// predicts the kept fraction per set and checks every result word against it
// depends on fets_pkg and fraction_extreme_tie_select
`timescale 1ns / 1ps

module tb_fraction_extreme_tie_select;

  localparam int unsigned VB = fets_pkg::ValueBitsDefault;

  typedef struct packed {
    logic [VB-1:0] den;
    logic [VB-1:0] num;
  } fraction_t;

  class fraction_scoreboard;
    logic          mode;
    logic [4:0]    dbits;
    logic [VB-1:0] kept_num;
    logic [VB-1:0] kept_den;
    logic          holding;
    fraction_t     best_q[$];
    int            errors;

    function new();
      mode     = 1'b0;
      dbits    = '0;
      kept_num = '0;
      kept_den = '0;
      holding  = 1'b0;
      errors   = 0;
    endfunction

    function bit prefers(logic [2*VB-1:0] x, logic [2*VB-1:0] y);
      return mode ? (x < y) : (x > y);
    endfunction

    function bit kept_wins(logic [VB-1:0] on, logic [VB-1:0] od);
      logic [2*VB-1:0] kept_x;
      logic [2*VB-1:0] offer_x;
      logic [VB-1:0]   mask;
      kept_x  = (2*VB)'(kept_num) * (2*VB)'(od);
      offer_x = (2*VB)'(on) * (2*VB)'(kept_den);
      if (dbits == 0 || dbits >= VB) mask = '1;
      else mask = (VB'(1) << dbits) - VB'(1);
      return prefers(kept_x, offer_x) ||
             (kept_x == offer_x && prefers({VB'(0), kept_den & mask}, {VB'(0), od & mask}));
    endfunction

    function void note_word(logic [VB-1:0] num, logic [VB-1:0] den, logic last);
      fraction_t best;
      if (!holding || !kept_wins(num, den)) begin
        kept_num = num;
        kept_den = den;
      end
      holding = 1'b1;
      if (last) begin
        best.num = kept_num;
        best.den = kept_den;
        best_q.push_back(best);
        kept_num = '0;
        kept_den = '0;
        holding  = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [VB-1:0] num, logic [VB-1:0] den);
      fraction_t best;
      if (best_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word num %h den %h", num, den));
      end else begin
        best = best_q.pop_front();
        if (num !== best.num)
          report_mismatch($sformatf("best_numerator %h, want %h", num, best.num));
        if (den !== best.den)
          report_mismatch($sformatf("best_denominator %h, want %h", den, best.den));
      end
    endtask

    function int pending();
      return best_q.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [fets_pkg::CfgAddrW-1:0] paddr = '0;
  logic [fets_pkg::CfgDataW-1:0] pwdata = '0;
  logic [fets_pkg::CfgDataW-1:0] prdata;
  logic                          pready;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [2*VB-1:0]               s_axis_tdata = '0;  // numerator, denominator
  logic                          s_axis_tlast = 1'b0;  // last_item
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [2*VB-1:0]               m_axis_tdata;  // best_numerator, best_denominator

  int tx_idle_pct = 16;
  int rx_idle_pct = 16;

  fraction_scoreboard sb = new();

  fraction_extreme_tie_select dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_word(s_axis_tdata[VB-1:0], s_axis_tdata[2*VB-1:VB], s_axis_tlast);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[VB-1:0], m_axis_tdata[2*VB-1:VB]);
  end

  task automatic send_word(input logic [VB-1:0] num, input logic [VB-1:0] den,
                           input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {den, num};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold off until every set has produced its word, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [fets_pkg::CfgAddrW-1:0] addr,
                           input logic [fets_pkg::CfgDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == fets_pkg::AddrSelectMode) sb.mode = data[0];
    else if (addr == fets_pkg::AddrDenCompareBits) sb.dbits = data[4:0];
  endtask

  task automatic configure(input logic mode, input logic [4:0] dbits);
    drain();
    apb_write(fets_pkg::AddrSelectMode, ($urandom & ~32'h1) | 32'(mode));
    apb_write(fets_pkg::AddrDenCompareBits, ($urandom & ~32'h1F) | 32'(dbits));
  endtask

  function automatic logic [VB-1:0] corner_value();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return VB'(1);
      2: return '1;
      3: return {1'b1, {(VB-1){1'b0}}};
      default: return {{(VB-1){1'b1}}, 1'b0};
    endcase
  endfunction

  // many words are scaled copies of one base fraction so that equal products are common
  task automatic send_set(input int len);
    logic [VB-1:0] base_n;
    logic [VB-1:0] base_d;
    logic [VB-1:0] num;
    logic [VB-1:0] den;
    int            k;
    int            pick;
    base_n = VB'($urandom_range(0, 255));
    base_d = VB'($urandom_range(0, 255));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        num = VB'($urandom);
        den = VB'($urandom);
      end else if (pick < 75) begin
        k   = $urandom_range(1, 256);
        num = VB'(base_n * k);
        den = VB'(base_d * k);
      end else if (pick < 90) begin
        num = corner_value();
        den = corner_value();
      end else begin
        num = VB'($urandom_range(0, 15));
        den = VB'($urandom_range(0, 15));
      end
      send_word(num, den, i == len - 1);
    end
  endtask

  initial begin
    logic       modes[7];
    logic [4:0] widths[7];
    int         items;
    int         len;
    modes  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    widths = '{5'd0, 5'd0, 5'd16, 5'd31, 5'd1, 5'd15, 5'd0};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone items, field extremes, ties and zero denominators under reset settings, then two narrowed tie-break settings
    send_word('1, '1, 1'b1);
    send_word('0, '0, 1'b1);
    send_word('0, VB'(1), 1'b0);
    send_word('1, VB'(1), 1'b0);
    send_word(VB'(1), '1, 1'b0);
    send_word('0, '0, 1'b1);
    send_word(VB'(1), VB'(2), 1'b0);
    send_word(VB'(2), VB'(4), 1'b0);
    send_word(VB'(3), VB'(6), 1'b0);
    send_word(VB'(4), VB'(8), 1'b1);
    send_word(VB'(5), '0, 1'b0);
    send_word(VB'(3), '0, 1'b0);
    send_word('0, '0, 1'b1);
    configure(1'b1, 5'd1);
    send_word(VB'(4), VB'(8), 1'b0);
    send_word(VB'(1), VB'(2), 1'b0);
    send_word(VB'(3), VB'(6), 1'b0);
    send_word(VB'(2), VB'(4), 1'b1);
    send_word('1, VB'(1), 1'b0);
    send_word('0, '1, 1'b1);
    configure(1'b0, 5'd2);
    send_word(VB'(6), VB'(6), 1'b0);
    send_word(VB'(5), VB'(5), 1'b0);
    send_word(VB'(7), VB'(7), 1'b1);

    modes[6]  = 1'($urandom_range(0, 1));
    widths[6] = 5'($urandom_range(0, 31));
    for (int phase = 0; phase < 7; phase++) begin
      configure(modes[phase], widths[phase]);
      tx_idle_pct = (phase == 2) ? 0 : 16;
      rx_idle_pct = (phase == 2) ? 0 : 16;
      items = 0;
      while (items < 250) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        send_set(len);
        items += len;
        if (phase == 3 && items >= 125 && items - len < 125) drain();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ fraction_extreme_tie_select.f @@
rtl/fets_pkg.sv
rtl/fets_cmp.sv
rtl/fraction_extreme_tie_select.sv
test/tb_fraction_extreme_tie_select.sv
